// File: rtl/edf_periodic_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// EDF scheduler assertion macros
// Shared concurrent assertion wrappers for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// General form: explicit clock and reset.
`define EDF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Block clock and reset.
`define EDF_ASSERT_CLK(name, prop, msg) `EDF_ASSERT(name, clock, reset, prop, msg)

`endif

// File: rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Widths, command codes, shared types and the saturating time adder.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TIME_W        = 32;
   localparam int PARAM_W       = 16;
   localparam int SLOT_W        = 4;
   localparam int COUNT_W       = 5;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 40;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Input item kinds carried on req_tuser.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // One task entry as stored and as updated.
   typedef struct packed {
      logic [TIME_W-1:0]  rel;
      logic [TIME_W-1:0]  dl;
      logic [PARAM_W-1:0] job;
      logic [PARAM_W-1:0] ival;
      logic [PARAM_W-1:0] offs;
      logic [PARAM_W-1:0] work;
   } entry_type;

   // Write enables of the task store, one per field group.
   typedef struct packed {
      logic params;
      logic times;
      logic work;
   } wr_ctrl_type;

   // Result of the shared entry unit.
   typedef struct packed {
      entry_type nxt;
      logic      better;
   } unit_res_type;

   // Add that sticks at the largest time value.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

endpackage

// File: rtl/edf_periodic_task_scheduler.sv
// ----------------------------------------------------------------------------
// EDF periodic task scheduler
// Earliest-deadline-first choice over periodic tasks, one decision per tick.
// ----------------------------------------------------------------------------
// A load item gives no result item.
// A tick item passes an accept state, a scan of each active task entry
// through the shared entry unit and the single task store read port, and a
// commit state that writes back the chosen entry; the commit waits while an
// earlier result item is unaccepted. The result item appears the cycle after the commit.
// Synchronous reset clears time, task count and all remaining work.
module edf_periodic_task_scheduler #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration: task_count.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [edf_pkg::COUNT_W-1:0]     csr_data,
   // Request tdata: task_slot[3:0], exec_time[19:4], task_period[35:20],
   // relative_deadline[51:36]; tuser: command.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [edf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   // Response tdata: tick_time[31:0], chosen_task[35:32]; tuser: idle.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [edf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);
   import edf_pkg::*;
   `include "edf_periodic_task_scheduler_defines.svh"

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] task_count_ff;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               found_ff, found_in;
   logic [TIME_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [PARAM_W-1:0] pick_work_ff, pick_work_in;
   logic               rsp_valid_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [SLOT_W-1:0]  rsp_task_ff;
   logic               rsp_idle_ff;
   logic               rsp_load;

   logic               req_fire;
   logic [SLOT_W-1:0]  req_slot;
   logic [PARAM_W-1:0] req_exec;
   logic [PARAM_W-1:0] req_period;
   logic [PARAM_W-1:0] req_deadline;
   logic [CNT_W-1:0]   active_cnt;

   entry_type          unit_cur;
   unit_res_type       unit_res;
   wr_ctrl_type        wr_ctrl;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   entry_type          rd_data;

   // Request fields.
   assign req_slot     = req_tdata[3:0];
   assign req_exec     = req_tdata[19:4];
   assign req_period   = req_tdata[35:20];
   assign req_deadline = req_tdata[51:36];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Counts above the store depth act as the depth.
   assign active_cnt = (int'(task_count_ff) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                         : CNT_W'(task_count_ff);

   // A load uses the unit with its release at the current time.
   always_comb begin
      if (state_ff == S_IDLE) begin
         unit_cur      = '0;
         unit_cur.rel  = time_ff;
         unit_cur.job  = req_exec;
         unit_cur.ival = req_period;
         unit_cur.offs = req_deadline;
      end else begin
         unit_cur = rd_data;
      end
   end

   edf_entry_unit u_unit (
      .now   (time_ff),
      .cur   (unit_cur),
      .best  (best_ff),
      .found (found_ff),
      .res   (unit_res)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      pick_work_in = pick_work_ff;
      rsp_load     = 1'b0;
      wr_ctrl      = '0;
      wr_addr      = pos_ff;
      wr_data      = unit_res.nxt;
      case (state_ff)
         S_IDLE: begin
            wr_addr = IDX_W'(req_slot);
            if (req_fire) begin
               if (req_tuser == CMD_TICK) begin
                  cnt_in   = active_cnt;
                  found_in = 1'b0;
                  state_in = (active_cnt == '0) ? S_DONE : S_SCAN;
               end else if (int'(req_slot) < MAX_TASKS) begin
                  wr_ctrl = '{params: 1'b1, times: 1'b1, work: 1'b1};
               end
            end
         end
         S_SCAN: begin
            // Release and compare the entry read in the previous cycle.
            wr_ctrl = '{params: 1'b0, times: 1'b1, work: 1'b1};
            if (unit_res.better) begin
               found_in     = 1'b1;
               best_in      = unit_res.nxt.dl;
               pick_in      = pos_ff;
               pick_work_in = unit_res.nxt.work;
            end
            if (CNT_W'(pos_ff) + CNT_W'(1) == cnt_ff) begin
               pos_in   = '0;
               state_in = S_DONE;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            // Charge one tick to the chosen task and report.
            wr_addr      = pick_ff;
            wr_data.work = pick_work_ff - PARAM_W'(1);
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               wr_ctrl.work = found_ff;
               time_in      = sat_add(time_ff, TIME_W'(1));
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            pos_in   = '0;
         end
      endcase
   end

   edf_task_store #(
      .MAX_TASKS (MAX_TASKS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_ctrl (wr_ctrl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= '0;
         time_ff       <= '0;
         pos_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
         if (csr_valid && csr_ready) begin
            task_count_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan and result payload registers.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      pick_work_ff <= pick_work_in;
      if (rsp_load) begin
         rsp_time_ff <= time_ff;
         rsp_task_ff <= found_ff ? SLOT_W'(pick_ff) : '0;
         rsp_idle_ff <= !found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - TIME_W){1'b0}}, rsp_task_ff, rsp_time_ff};
   assign rsp_tuser  = rsp_idle_ff;

   // Checks.
   `EDF_ASSERT_CLK(a_scan_in_range,
      (state_ff == S_SCAN) |-> (CNT_W'(pos_ff) < cnt_ff),
      "scan position beyond active task count")
   `EDF_ASSERT_CLK(a_tick_leaves_idle,
      (req_fire && (req_tuser == CMD_TICK)) |=> (state_ff != S_IDLE),
      "tick item did not start a decision")
   `EDF_ASSERT_CLK(a_pick_in_range,
      ((state_ff == S_DONE) && found_ff) |-> (CNT_W'(pick_ff) < cnt_ff),
      "chosen task outside active task range")
   `EDF_ASSERT_CLK(a_time_advanced,
      rsp_valid_ff |-> (time_ff != '0),
      "time did not advance after a decision")

endmodule

// File: rtl/edf_entry_unit.sv
// ----------------------------------------------------------------------------
// EDF entry unit
// Shared release and compare logic, applied to one task entry per cycle.
// ----------------------------------------------------------------------------
module edf_entry_unit (
   input  logic [edf_pkg::TIME_W-1:0] now,
   input  edf_pkg::entry_type         cur,
   input  logic [edf_pkg::TIME_W-1:0] best,
   input  logic                       found,
   output edf_pkg::unit_res_type      res
);
   import edf_pkg::*;

   logic hit;

   // A job is released when the next release time equals the current time.
   assign hit = (cur.rel == now);

   always_comb begin
      res.nxt      = cur;
      if (hit) begin
         res.nxt.work = cur.job;
         res.nxt.dl   = sat_add(now, TIME_W'(cur.offs));
         res.nxt.rel  = sat_add(cur.rel, TIME_W'(cur.ival));
      end
      // Ready entries compete on absolute deadline; a tie keeps the earlier one.
      res.better = (res.nxt.work != '0) && (!found || (res.nxt.dl < best));
   end

endmodule

// File: rtl/edf_task_store.sv
// ----------------------------------------------------------------------------
// EDF task store
// Per-task memories with one write and one registered read port.
// ----------------------------------------------------------------------------
module edf_task_store #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  edf_pkg::wr_ctrl_type         wr_ctrl,
   input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
   input  edf_pkg::entry_type           wr_data,
   input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
   output edf_pkg::entry_type           rd_data
);
   import edf_pkg::*;

   logic [TIME_W-1:0]  rel_ff  [MAX_TASKS];
   logic [TIME_W-1:0]  dl_ff   [MAX_TASKS];
   logic [PARAM_W-1:0] job_ff  [MAX_TASKS];
   logic [PARAM_W-1:0] ival_ff [MAX_TASKS];
   logic [PARAM_W-1:0] offs_ff [MAX_TASKS];
   logic [PARAM_W-1:0] work_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] work_valid_ff;
   entry_type          rd_ff;
   logic               rd_valid_ff;

   // Memory writes and registered read.
   always_ff @(posedge clock) begin
      if (wr_ctrl.params) begin
         job_ff[wr_addr]  <= wr_data.job;
         ival_ff[wr_addr] <= wr_data.ival;
         offs_ff[wr_addr] <= wr_data.offs;
      end
      if (wr_ctrl.times) begin
         rel_ff[wr_addr] <= wr_data.rel;
         dl_ff[wr_addr]  <= wr_data.dl;
      end
      if (wr_ctrl.work) begin
         work_ff[wr_addr] <= wr_data.work;
      end
      rd_ff.rel  <= rel_ff[rd_addr];
      rd_ff.dl   <= dl_ff[rd_addr];
      rd_ff.job  <= job_ff[rd_addr];
      rd_ff.ival <= ival_ff[rd_addr];
      rd_ff.offs <= offs_ff[rd_addr];
      rd_ff.work <= work_ff[rd_addr];
   end

   // Remaining work reads as zero until an entry has been written.
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (wr_ctrl.work) begin
            work_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= work_valid_ff[rd_addr];
      end
   end

   always_comb begin
      rd_data = rd_ff;
      if (!rd_valid_ff) begin
         rd_data.work = '0;
      end
   end

endmodule

// File: dv/edf_periodic_task_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF periodic task scheduler testbench
// Feeds task loads and time ticks through the request stream, predicts every
// scheduling decision with a local earliest-deadline-first model and checks
// each response item field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_test;
   import edf_pkg::*;

   localparam int SLOTS         = MAX_TASKS_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int TARGET_ITEMS  = 1850;
   localparam int HOLD_CYCLES   = 400;

   // One request item as the sender offers it.
   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [PARAM_W-1:0] exec_len;
      logic [PARAM_W-1:0] period;
      logic [PARAM_W-1:0] rel_dl;
      logic               drain_first;
   } sched_req_type;

   // One scheduling decision as the block should report it.
   typedef struct packed {
      logic [TIME_W-1:0] tick;
      logic [SLOT_W-1:0] task_id;
      logic              idle;
   } decision_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // slot, exec, period, deadline
   logic                  req_tuser  = 1'b0; // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // tick_time, chosen_task
   logic                  rsp_tuser;        // idle

   edf_periodic_task_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Local copy of the scheduler state.
   logic [COUNT_W-1:0] model_count;
   logic [TIME_W-1:0]  model_now;
   logic [PARAM_W-1:0] model_work     [SLOTS];
   logic [TIME_W-1:0]  model_release  [SLOTS];
   logic [TIME_W-1:0]  model_deadline [SLOTS];
   logic [PARAM_W-1:0] model_job      [SLOTS];
   logic [PARAM_W-1:0] model_period   [SLOTS];
   logic [PARAM_W-1:0] model_offset   [SLOTS];

   sched_req_type  pending_reqs [$];
   decision_type   decisions_due [$];
   sched_req_type  offered;
   int unsigned items_queued  = 0;
   int unsigned loads_done    = 0;
   int unsigned ticks_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned idle_seen     = 0;
   int unsigned settings_used = 0;
   int unsigned mismatches    = 0;
   int unsigned send_gap      = 0;
   int unsigned recv_wait     = 0;
   int unsigned hold_left     = 0;
   bit          hold_kick      = 1'b0;
   bit          quiet_sender   = 1'b0;
   bit          quiet_receiver = 1'b0;

   // Time addition that sticks at the largest value.
   function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
      if (a > TIME_MAX - b) return TIME_MAX;
      return a + b;
   endfunction

   // Apply one accepted item to the local state; a tick queues its decision.
   task automatic schedule_item(input sched_req_type it);
      int                live;
      int                pick;
      bit                found;
      logic [TIME_W-1:0] best;
      decision_type      d;
      if (it.kind == CMD_LOAD) begin
         model_job[it.slot]      = it.exec_len;
         model_period[it.slot]   = it.period;
         model_offset[it.slot]   = it.rel_dl;
         model_work[it.slot]     = it.exec_len;
         model_deadline[it.slot] = time_add(model_now, TIME_W'(it.rel_dl));
         model_release[it.slot]  = time_add(model_now, TIME_W'(it.period));
         loads_done++;
      end else begin
         live = (model_count > SLOTS) ? SLOTS : model_count;
         // Release every job whose time has come.
         for (int i = 0; i < live; i++) begin
            if (model_release[i] == model_now) begin
               model_work[i]     = model_job[i];
               model_deadline[i] = time_add(model_now, TIME_W'(model_offset[i]));
               model_release[i]  = time_add(model_release[i], TIME_W'(model_period[i]));
            end
         end
         // Earliest deadline among ready tasks; the lower index keeps a tie.
         found = 1'b0;
         pick  = 0;
         best  = '0;
         for (int i = 0; i < live; i++) begin
            if (model_work[i] != 0 && (!found || model_deadline[i] < best)) begin
               found = 1'b1;
               best  = model_deadline[i];
               pick  = i;
            end
         end
         d.tick    = model_now;
         d.task_id = found ? pick[SLOT_W-1:0] : '0;
         d.idle    = !found;
         if (found) model_work[pick] = model_work[pick] - PARAM_W'(1);
         decisions_due.push_back(d);
         model_now = time_add(model_now, TIME_W'(1));
         ticks_sent++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch at %0t on %s: expected %0h, got %0h", $time, what, want_v, got_v);
   endtask

   // Request driver: offers queued items, with a random gap after each one.
   always @(posedge clock) begin
      bit showing;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         showing = req_tvalid;
         if (req_tvalid && req_tready) begin
            schedule_item(offered);
            showing  = 1'b0;
            send_gap = quiet_sender ? 0 : $urandom_range(0, 19);
         end
         if (!showing) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain_first || results_seen == ticks_sent)) begin
               offered = pending_reqs.pop_front();
               req_tdata <= {4'b0000, offered.rel_dl, offered.period, offered.exec_len,
                             offered.slot};
               req_tuser <= offered.kind;
               showing = 1'b1;
            end
         end
         req_tvalid <= showing;
      end
   end

   // Long receiver hold-off, started by a one-cycle kick.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each item against the oldest decision due.
   always @(posedge clock) begin
      decision_type want;
      bit           ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (decisions_due.size() == 0) begin
               report_mismatch("result item with nothing due", '0, 64'(rsp_tdata));
            end else begin
               want = decisions_due.pop_front();
               if (rsp_tdata[31:0] !== want.tick)
                  report_mismatch("tick_time", 64'(want.tick), 64'(rsp_tdata[31:0]));
               if (rsp_tdata[35:32] !== want.task_id)
                  report_mismatch("chosen_task", 64'(want.task_id), 64'(rsp_tdata[35:32]));
               if (rsp_tuser !== want.idle)
                  report_mismatch("idle", 64'(want.idle), 64'(rsp_tuser));
               if (want.idle) idle_seen++;
            end
            recv_wait = quiet_receiver ? 0 : $urandom_range(0, 19);
         end
         if (hold_left != 0) begin
            ready_next = 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // Parameter values: mostly small so that jobs finish and recur often.
   function automatic logic [PARAM_W-1:0] draw_param(input int common_max);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 12) return PARAM_W'($urandom_range(0, 65535));
      if (r < 14) return '1;
      return PARAM_W'($urandom_range(1, common_max));
   endfunction

   function automatic sched_req_type load_item(input logic [SLOT_W-1:0] slot,
                                               input logic [PARAM_W-1:0] exec_len,
                                               input logic [PARAM_W-1:0] period,
                                               input logic [PARAM_W-1:0] rel_dl);
      sched_req_type it;
      it.kind        = CMD_LOAD;
      it.slot        = slot;
      it.exec_len    = exec_len;
      it.period      = period;
      it.rel_dl      = rel_dl;
      it.drain_first = 1'b0;
      return it;
   endfunction

   // A tick carries random payload bits, which the block must ignore.
   function automatic sched_req_type tick_item(input logic drain_first);
      sched_req_type it;
      it.kind        = CMD_TICK;
      it.slot        = SLOT_W'($urandom_range(0, SLOTS - 1));
      it.exec_len    = PARAM_W'($urandom_range(0, 65535));
      it.period      = PARAM_W'($urandom_range(0, 65535));
      it.rel_dl      = PARAM_W'($urandom_range(0, 65535));
      it.drain_first = drain_first;
      return it;
   endfunction

   task automatic enqueue(input sched_req_type it);
      pending_reqs.push_back(it);
      items_queued++;
   endtask

   // Wait until every item is in and every decision is out, then settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || results_seen != ticks_sent);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_task_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      model_count = value;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // One random phase: new task count, fresh loads of every active slot,
   // then a mix of ticks and reloads.
   task automatic run_phase(input logic [COUNT_W-1:0] setting, input int length,
                            input bit with_hold);
      int live;
      wait_idle();
      write_task_count(setting);
      live = (setting > SLOTS) ? SLOTS : setting;
      @(negedge clock);
      quiet_sender   = with_hold || ($urandom_range(0, 3) == 0);
      quiet_receiver = !with_hold && ($urandom_range(0, 3) == 0);
      if (with_hold) hold_kick = 1'b1;
      for (int s = 0; s < live; s++)
         enqueue(load_item(s[SLOT_W-1:0], draw_param(6), draw_param(16), draw_param(20)));
      for (int k = 0; k < length; k++) begin
         if ($urandom_range(0, 99) < 15)
            enqueue(load_item(SLOT_W'($urandom_range(0, SLOTS - 1)), draw_param(6),
                              draw_param(16), draw_param(20)));
         else
            enqueue(tick_item($urandom_range(0, 99) == 0));
      end
      @(negedge clock);
      hold_kick = 1'b0;
   endtask

   // Stimulus: directed opening, then random phases.
   initial begin
      logic [COUNT_W-1:0] setting;
      int                 phase_no;
      model_now   = '0;
      model_count = '0;
      for (int s = 0; s < SLOTS; s++) begin
         model_work[s]     = '0;
         model_release[s]  = '0;
         model_deadline[s] = '0;
         model_job[s]      = '0;
         model_period[s]   = '0;
         model_offset[s]   = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // No tasks at all: every tick is idle.
      write_task_count('0);
      @(negedge clock);
      enqueue(tick_item(1'b0));
      enqueue(tick_item(1'b0));
      // Largest fields, a job that is never ready, a zero period with a zero
      // deadline, and two tasks with equal deadlines.
      enqueue(load_item(4'd15, '1, '1, '1));
      enqueue(load_item(4'd0, '0, '1, '1));
      enqueue(load_item(4'd1, 16'd2, '0, '0));
      enqueue(load_item(4'd2, 16'd3, 16'd4, 16'd4));
      enqueue(load_item(4'd3, 16'd2, 16'd4, 16'd4));
      wait_idle();
      write_task_count(5'd4);
      @(negedge clock);
      repeat (4) enqueue(tick_item(1'b0));
      enqueue(load_item(4'd2, 16'd1, 16'd3, 16'd1));
      // The sender holds this tick back until all decisions are in.
      enqueue(tick_item(1'b1));
      repeat (4) enqueue(tick_item(1'b0));

      // Random phases; the first uses an oversized count, the fourth a long
      // receiver hold-off.
      phase_no = 0;
      while (items_queued < TARGET_ITEMS) begin
         if (phase_no == 0)
            setting = '1;
         else if (phase_no == 1)
            setting = 5'd16;
         else if ($urandom_range(0, 6) == 0)
            setting = COUNT_W'($urandom_range(17, 31));
         else
            setting = COUNT_W'($urandom_range(0, 16));
         run_phase(setting, $urandom_range(30, 110), phase_no == 3);
         phase_no++;
      end
      wait_idle();

      if (decisions_due.size() != 0) begin
         mismatches += decisions_due.size();
         $display("%0d expected decisions never arrived", decisions_due.size());
      end
      $display("Ran %0d task loads and %0d ticks (%0d idle) over %0d task-count writes.",
               loads_done, ticks_sent, idle_seen, settings_used);
      $display("Included empty and oversized task sets, deadline ties, zero periods, "
               , "never-ready jobs and a long response stall.");
      if (mismatches == 0) begin
         $display("edf_periodic_task_scheduler regression: pass");
      end else begin
         $display("edf_periodic_task_scheduler regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #6000000;
      $display("Timed out with %0d decisions still due", decisions_due.size());
      $display("edf_periodic_task_scheduler regression: fail");
      $finish;
   end

endmodule
